// ===== hdl/snd_pkg.sv =====
package snd_pkg;

  localparam int unsigned NUM_INPUTS_DEF = 16;
  localparam int unsigned SIG_DEPTH_DEF  = 256;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam logic [15:0] RATE_RST       = 16'd6554;

  typedef enum logic [2:0] {
    OP_INPUT = 3'd0,
    OP_TRAIN = 3'd1,
    OP_WRW   = 3'd2,
    OP_RDW   = 3'd3,
    OP_RDE   = 3'd4
  } snd_op_e;

  typedef enum logic [1:0] {
    KIND_OUT  = 2'd0,
    KIND_WRD  = 2'd1,
    KIND_WERR = 2'd2,
    KIND_TRN  = 2'd3
  } snd_kind_e;

  typedef enum logic [1:0] {
    CFG_HIDDEN = 2'd0,
    CFG_IRATE  = 2'd1,
    CFG_DECAY  = 2'd2
  } snd_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FWD, ST_SUM, ST_SIG, ST_TE1, ST_TE2, ST_TE3, ST_TRN,
    ST_RATE1, ST_RATE2, ST_RD, ST_WE, ST_OUT
  } snd_state_e;

  // One row of the neuron store: input sample, weight, weight snapshot.
  typedef struct packed {
    logic signed [15:0] inp;
    logic signed [15:0] wgt;
    logic signed [15:0] old;
  } snd_row_t;

  // Per-field write enables of a row.
  typedef struct packed {
    logic inp;
    logic wgt;
    logic old;
  } snd_fld_t;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    logic signed [15:0] r;
    if (v > 50'sd32767) r = 16'sh7fff;
    else if (v < -50'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic is_sat(input logic signed [49:0] v);
    return (v > 50'sd32767) || (v < -50'sd32768);
  endfunction

  // Logistic value at the center of cell k of a table with 2**lg cells
  // spanning [-8, 8), rounded to Q.12. Elaboration time only.
  function automatic logic [12:0] sig_entry(input int unsigned k, input int unsigned lg);
    longint x;
    longint ax;
    longint sum;
    longint den;
    longint unsigned u;
    longint unsigned term;
    longint unsigned t;
    longint unsigned num;
    longint unsigned r;
    longint unsigned q;
    x = ((longint'(2 * k + 1) * (longint'(8) <<< 30)) >>> lg) - (longint'(8) <<< 30);
    ax = (x < 0) ? -x : x;
    u = longint'(unsigned'(ax)) >> 4;
    term = 64'd1 << 30;
    sum = longint'(1) <<< 30;
    for (int n = 1; n <= 12; n++) begin
      t = (term * u) >> 30;
      case (n)
        2: t = t / 2;
        3: t = t / 3;
        4: t = t / 4;
        5: t = t / 5;
        6: t = t / 6;
        7: t = t / 7;
        8: t = t / 8;
        9: t = t / 9;
        10: t = t / 10;
        11: t = t / 11;
        12: t = t / 12;
        default: t = t;
      endcase
      term = t;
      if ((n % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    for (int n = 0; n < 4; n++) begin
      sum = longint'((longint'(unsigned'(sum)) * longint'(unsigned'(sum))) >> 30);
    end
    den = (longint'(1) <<< 30) + sum;
    num = (x < 0) ? 64'(4096 * sum) : (64'd4096 << 30);
    num = num + 64'(den >>> 1);
    r = 0;
    q = 0;
    for (int b = 47; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= 64'(den)) begin
        r = r - 64'(den);
        q = q | (64'd1 << b);
      end
    end
    return q[12:0];
  endfunction

endpackage

// ===== hdl/snd_if.sv =====
interface snd_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [3:0]        index;
  logic signed [15:0] value;
  logic              last;
  modport source (output valid, opcode, index, value, last, input ready);
  modport sink   (input valid, opcode, index, value, last, output ready);
endinterface

interface snd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [15:0] result_value;
  logic               saturated;
  modport source (output valid, result_kind, result_value, saturated, input ready);
  modport sink   (input valid, result_kind, result_value, saturated, output ready);
endinterface

// ===== hdl/snd_mem.sv =====
module snd_mem #(
  parameter int unsigned DEPTH = snd_pkg::NUM_INPUTS_DEF,
  parameter int unsigned AW    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  snd_pkg::snd_fld_t wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  snd_pkg::snd_row_t wr_row_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output snd_pkg::snd_row_t rd_row_o
);
  import snd_pkg::*;

  snd_row_t          mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  snd_row_t          rd_row_q;
  logic              rd_vld_q;
  logic              wr_any;

  assign wr_any = wr_en_i.inp | wr_en_i.wgt | wr_en_i.old;

  // A row never written reads as zero; its first write zeroes the other fields.
  always_ff @(posedge clk_i) begin
    if (wr_any) begin
      if (wr_en_i.inp) mem_q[wr_addr_i].inp <= wr_row_i.inp;
      else if (!vld_q[wr_addr_i]) mem_q[wr_addr_i].inp <= '0;
      if (wr_en_i.wgt) mem_q[wr_addr_i].wgt <= wr_row_i.wgt;
      else if (!vld_q[wr_addr_i]) mem_q[wr_addr_i].wgt <= '0;
      if (wr_en_i.old) mem_q[wr_addr_i].old <= wr_row_i.old;
      else if (!vld_q[wr_addr_i]) mem_q[wr_addr_i].old <= '0;
    end
    if (rd_en_i) rd_row_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_any) vld_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_row_o = rd_vld_q ? rd_row_q : '0;

endmodule

// ===== hdl/snd_sig.sv =====
module snd_sig #(
  parameter int unsigned DEPTH = snd_pkg::SIG_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic signed [15:0] sum_i,
  output logic [12:0]        y_o
);
  import snd_pkg::*;

  localparam int unsigned TBW = $clog2(DEPTH);

  logic [12:0] tab [DEPTH];
  logic [15:0] ofs;
  logic [12:0] y_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    localparam logic [12:0] V = sig_entry(g, TBW);
    assign tab[g] = V;
  end

  // Offset-binary sum; its top bits pick the cell.
  assign ofs = {~sum_i[15], sum_i[14:0]};

  always_ff @(posedge clk_i) begin
    y_q <= tab[ofs[15 -: TBW]];
  end

  assign y_o = y_q;

endmodule

// ===== hdl/sigmoid_neuron_delta_rule.sv =====
// Channel | Dir | Payload                                   | Accepted when
// in_i    | in  | opcode, index, value, last                | valid && ready
// out_o   | out | result_kind, result_value, saturated      | valid && ready
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i           | cfg_we_i high
//
// One item at a time. The forward pass (input with last) and training
// both walk the neuron store through the single multiply-accumulate
// unit. Reset clears all stores at once through row valid bits; no
// clearing pass. A result waits in the output register while the next
// item is taken; a stalled output holds only the final push state.
module sigmoid_neuron_delta_rule #(
  parameter int unsigned NUM_INPUTS          = snd_pkg::NUM_INPUTS_DEF,
  parameter int unsigned SIGMOID_TABLE_DEPTH = snd_pkg::SIG_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  snd_in_if.sink                           in_i,
  snd_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [snd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [snd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import snd_pkg::*;

  localparam int unsigned AW    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int unsigned CW    = $clog2(NUM_INPUTS + 1);
  localparam int unsigned ACC_W = 33 + CW;

  snd_state_e state_q, state_d;

  // configuration
  logic        hidden_q;
  logic [15:0] decay_q;
  logic [15:0] rate_q;

  // neuron state
  logic [12:0]        o_q;
  logic signed [15:0] err_q;

  // item and arithmetic registers
  logic               it_rdw_q;
  logic               it_rng_q;
  logic signed [16:0] d_q;
  logic [22:0]        p1_q;
  logic signed [33:0] re_q;
  logic [31:0]        rd_q;
  logic signed [31:0] we_q;
  logic signed [ACC_W-1:0] acc_q;
  logic               clip_q;

  // store walk
  logic [CW-1:0]      cnt_q;
  logic               rd_v_q;
  logic [AW-1:0]      rd_a_q;
  logic               p_v_q;
  logic [AW-1:0]      p_a_q;
  logic signed [49:0] p_prod_q;
  logic signed [15:0] p_in_q;
  logic signed [15:0] p_w_q;

  // result staging and output register
  logic [1:0]         res_kind_q;
  logic signed [15:0] res_val_q;
  logic               res_sat_q;
  logic               out_valid_q;
  logic [1:0]         out_kind_q;
  logic signed [15:0] out_val_q;
  logic               out_sat_q;

  logic               accept;
  logic               in_rng;
  logic [AW-1:0]      idx_a;
  logic               walking;
  logic               issue;
  logic               walk_done;
  logic               push;

  snd_fld_t           mem_we;
  logic [AW-1:0]      mem_wa;
  snd_row_t           mem_wrow;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;
  snd_row_t           row;

  logic signed [49:0] prod;
  logic signed [49:0] wsum;
  logic signed [15:0] new_w;
  logic signed [49:0] sum_ext;
  logic signed [15:0] sum_sat;
  logic [12:0]        sig_y;
  logic [25:0]        p1;
  logic signed [40:0] p2;
  logic [15:0]        rate_new;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_rng    = (9'(in_i.index) < 9'(NUM_INPUTS));
  assign idx_a     = AW'(in_i.index);
  assign walking   = (state_q == ST_FWD) || (state_q == ST_TRN);
  assign issue     = walking && (cnt_q < CW'(NUM_INPUTS));
  assign walk_done = (cnt_q == CW'(NUM_INPUTS)) && !rd_v_q && !p_v_q;
  assign push      = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // weight update: floor of rate*error*input over 2^28, saturated
  assign wsum  = 50'(p_w_q) + (p_prod_q >>> 28);
  assign new_w = sat16(wsum);

  // Store ports: item writes in idle, weight write-back during training.
  always_comb begin
    mem_we   = '0;
    mem_wa   = idx_a;
    mem_wrow = '{inp: in_i.value, wgt: in_i.value, old: '0};
    if (accept && in_rng) begin
      if (in_i.opcode == OP_INPUT) mem_we.inp = 1'b1;
      if (in_i.opcode == OP_WRW) mem_we.wgt = 1'b1;
    end
    if ((state_q == ST_TRN) && p_v_q) begin
      mem_we   = '{inp: 1'b1, wgt: 1'b1, old: 1'b1};
      mem_wa   = p_a_q;
      mem_wrow = '{inp: p_in_q, wgt: new_w, old: p_w_q};
    end
  end

  assign mem_re = issue || (accept && ((in_i.opcode == OP_RDW) || (in_i.opcode == OP_RDE)));
  assign mem_ra = issue ? cnt_q[AW-1:0] : idx_a;

  snd_mem #(.DEPTH(NUM_INPUTS), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_wa),
    .wr_row_i  (mem_wrow),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_ra),
    .rd_row_o  (row)
  );

  assign sum_ext = 50'(acc_q >>> 12);
  assign sum_sat = sat16(sum_ext);

  snd_sig #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
    .clk_i (clk_i),
    .sum_i (sum_sat),
    .y_o   (sig_y)
  );

  // shared multiplier: input*weight forward, (rate*error)*input in training
  assign prod     = (state_q == ST_TRN) ? (re_q * row.inp) : 50'(row.inp * row.wgt);
  assign p1       = o_q * (13'd4096 - o_q);
  assign p2       = $signed({1'b0, p1_q}) * d_q;
  assign rate_new = rate_q - rd_q[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.opcode)
            OP_INPUT: state_d = in_i.last ? ST_FWD : ST_IDLE;
            OP_TRAIN: state_d = ST_TE1;
            OP_RDW, OP_RDE: state_d = ST_RD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FWD:   if (walk_done) state_d = ST_SUM;
      ST_SUM:   state_d = ST_SIG;
      ST_SIG:   state_d = ST_OUT;
      ST_TE1:   state_d = ST_TE2;
      ST_TE2:   state_d = ST_TE3;
      ST_TE3:   state_d = ST_TRN;
      ST_TRN:   if (walk_done) state_d = ST_RATE1;
      ST_RATE1: state_d = ST_RATE2;
      ST_RATE2: state_d = ST_OUT;
      ST_RD:    state_d = it_rdw_q ? ST_OUT : ST_WE;
      ST_WE:    state_d = ST_OUT;
      ST_OUT:   if (push) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidden_q    <= 1'b0;
      decay_q     <= '0;
      rate_q      <= RATE_RST;
      o_q         <= '0;
      err_q       <= '0;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      p_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HIDDEN) hidden_q <= cfg_data_i[0];
        if (cfg_idx_i == CFG_IRATE) rate_q <= cfg_data_i;
        if (cfg_idx_i == CFG_DECAY) decay_q <= cfg_data_i;
      end
      if (accept) cnt_q <= '0;
      else if (issue) cnt_q <= cnt_q + 1'b1;
      rd_v_q <= issue;
      p_v_q  <= rd_v_q;
      if (state_q == ST_SIG) o_q <= sig_y;
      if (state_q == ST_TE2) err_q <= p2[39:24];
      if (state_q == ST_RATE2) rate_q <= rate_new;
      if (push) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rd_a_q   <= cnt_q[AW-1:0];
    p_a_q    <= rd_a_q;
    p_prod_q <= prod;
    p_in_q   <= row.inp;
    p_w_q    <= row.wgt;
    if (push) begin
      out_kind_q <= res_kind_q;
      out_val_q  <= res_val_q;
      out_sat_q  <= res_sat_q;
    end
    case (state_q)
      ST_IDLE: begin
        acc_q    <= '0;
        clip_q   <= 1'b0;
        it_rdw_q <= (in_i.opcode == OP_RDW);
        it_rng_q <= in_rng;
        d_q      <= hidden_q ? 17'(in_i.value) : (17'(in_i.value) - $signed({4'b0, o_q}));
      end
      ST_FWD: begin
        if (p_v_q) acc_q <= acc_q + ACC_W'(p_prod_q);
      end
      ST_SUM: clip_q <= is_sat(sum_ext);
      ST_SIG: begin
        res_kind_q <= KIND_OUT;
        res_val_q  <= {3'b0, sig_y};
        res_sat_q  <= clip_q;
      end
      ST_TE1: p1_q <= p1[22:0];
      ST_TE3: re_q <= $signed({1'b0, rate_q}) * err_q;
      ST_TRN: begin
        if (p_v_q && is_sat(wsum)) clip_q <= 1'b1;
      end
      ST_RATE1: rd_q <= rate_q * decay_q;
      ST_RATE2: begin
        res_kind_q <= KIND_TRN;
        res_val_q  <= rate_new;
        res_sat_q  <= clip_q;
      end
      ST_RD: begin
        res_kind_q <= KIND_WRD;
        res_val_q  <= it_rng_q ? row.wgt : '0;
        res_sat_q  <= 1'b0;
        we_q       <= err_q * row.old;
      end
      ST_WE: begin
        res_kind_q <= KIND_WERR;
        res_val_q  <= it_rng_q ? sat16(50'(we_q >>> 12)) : '0;
        res_sat_q  <= it_rng_q && is_sat(50'(we_q >>> 12));
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_kind_q;
  assign out_o.result_value = out_val_q;
  assign out_o.saturated    = out_sat_q;

endmodule

// ===== hdl/snd_chk.sv =====
module snd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic signed [15:0] out_value,
  input logic               out_sat
);
  import snd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_kind))
    else $error("result changed while stalled");

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_OUT) |-> (out_value >= 0) && (out_value <= 16'sd4096))
    else $error("neuron output outside the logistic range");

  a_rd_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_WRD) |-> !out_sat)
    else $error("weight read flagged saturated");

endmodule

bind sigmoid_neuron_delta_rule snd_chk u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.result_kind),
  .out_value (out_o.result_value),
  .out_sat   (out_o.saturated)
);

// ===== tb/snd_checker.sv =====
`timescale 1ns / 100ps

module snd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  snd_in_if           in_c,
  snd_out_if          out_c,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          checked_o,
  output int          clipped_o
);
  import snd_pkg::*;

  localparam int unsigned N_IN  = 16;
  localparam int unsigned DEPTH = 256;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] val;
    logic               sat;
  } neuron_res_t;

  neuron_res_t        res_q[$];
  logic [15:0]        logistic_lut[DEPTH];
  logic signed [15:0] x_mem[N_IN];
  logic signed [15:0] w_mem[N_IN];
  logic signed [15:0] w_snap[N_IN];
  longint             act;
  longint             grad;
  logic               hidden;
  logic [15:0]        rate_init;
  logic [15:0]        rate_now;
  logic [15:0]        decay;
  bit                 clip_hit;
  int                 fails;
  int                 checked;
  int                 clipped;

  assign fail_cnt_o = fails;
  assign pending_o  = res_q.size();
  assign checked_o  = checked;
  assign clipped_o  = clipped;

  // e^(-a) in Q2.30 by a series on a/16, then squared four times
  function automatic longint exp_neg(longint a);
    longint unsigned u;
    longint unsigned term;
    longint unsigned sq;
    longint          acc;
    u    = longint'(a) >> 4;
    term = 64'd1 << 30;
    acc  = longint'(1) <<< 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * u) >> 30) / n;
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    for (int n = 0; n < 4; n++) begin
      sq  = acc;
      acc = longint'((sq * sq) >> 30);
    end
    return acc;
  endfunction

  function automatic void fill_lut();
    longint x;
    longint e;
    longint den;
    longint num;
    for (int k = 0; k < DEPTH; k++) begin
      x   = ((2 * longint'(k) + 1) * (longint'(8) <<< 30)) / DEPTH - (longint'(8) <<< 30);
      e   = exp_neg(x < 0 ? -x : x);
      den = (longint'(1) <<< 30) + e;
      num = (x < 0) ? 4096 * e : 4096 * (longint'(1) <<< 30);
      logistic_lut[k] = 16'((num + den / 2) / den);
    end
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) begin
      clip_hit = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      clip_hit = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fails++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Advance the neuron model by one accepted item; queue its result if any.
  task automatic predict_neuron(logic [2:0] op, logic [3:0] ix, logic signed [15:0] v,
                                logic lst);
    neuron_res_t r;
    longint      acc;
    longint      s;
    longint      d;
    longint      dw;
    clip_hit = 1'b0;
    r = '0;
    case (op)
      OP_INPUT: begin
        x_mem[ix] = v;
        if (!lst) return;
        acc = 0;
        for (int i = 0; i < N_IN; i++) acc += longint'(x_mem[i]) * longint'(w_mem[i]);
        s   = clip16(acc >>> 12);
        act = logistic_lut[(s + 32768) >> 8];
        r.kind = KIND_OUT;
        r.val  = 16'(act);
      end
      OP_TRAIN: begin
        d    = hidden ? longint'(v) : longint'(v) - act;
        grad = (act * (4096 - act) * d) >>> 24;
        for (int i = 0; i < N_IN; i++) begin
          w_snap[i] = w_mem[i];
          dw = (longint'(rate_now) * grad * longint'(x_mem[i])) >>> 28;
          w_mem[i] = 16'(clip16(longint'(w_mem[i]) + dw));
        end
        rate_now = rate_now - 16'((longint'(rate_now) * longint'(decay)) >> 16);
        r.kind = KIND_TRN;
        r.val  = rate_now;
      end
      OP_WRW: begin
        w_mem[ix] = v;
        return;
      end
      OP_RDW: begin
        r.kind = KIND_WRD;
        r.val  = w_mem[ix];
      end
      OP_RDE: begin
        r.kind = KIND_WERR;
        r.val  = 16'(clip16((grad * longint'(w_snap[ix])) >>> 12));
      end
      default: return;
    endcase
    r.sat = clip_hit;
    res_q.insert(res_q.size(), r);
  endtask

  initial fill_lut();

  always @(posedge clk_i or negedge rst_ni) begin
    neuron_res_t want;
    if (!rst_ni) begin
      res_q.delete();
      for (int i = 0; i < N_IN; i++) begin
        x_mem[i]  = '0;
        w_mem[i]  = '0;
        w_snap[i] = '0;
      end
      act       = 0;
      grad      = 0;
      hidden    = 1'b0;
      rate_init = RATE_RST;
      rate_now  = RATE_RST;
      decay     = '0;
    end else begin
      // drain first: a result never belongs to an item taken at the same edge
      if (out_c.valid && out_c.ready) begin
        if (res_q.size() == 0) begin
          report("unexpected result", {out_c.result_kind, out_c.result_value}, '0);
        end else begin
          want = res_q.pop_front();
          checked++;
          if (out_c.saturated) clipped++;
          if (out_c.result_kind !== want.kind)
            report("result_kind", out_c.result_kind, want.kind);
          if (out_c.result_value !== want.val)
            report("result_value", out_c.result_value, want.val);
          if (out_c.saturated !== want.sat)
            report("saturated", out_c.saturated, want.sat);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HIDDEN: hidden = cfg_data_i[0];
          CFG_IRATE: begin
            rate_init = cfg_data_i;
            rate_now  = cfg_data_i;
          end
          CFG_DECAY: decay = cfg_data_i;
          default: ;
        endcase
      end
      if (in_c.valid && in_c.ready)
        predict_neuron(in_c.opcode, in_c.index, in_c.value, in_c.last);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import snd_pkg::*;

  // opcodes past the defined set; the block must drop them
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // register index with no register behind it
  localparam logic [1:0] CFG_NONE    = 2'd3;
  localparam int unsigned N_IN       = 16;
  localparam int unsigned ITEM_GOAL  = 1700;
  localparam int unsigned N_PHASE    = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  int          fail_cnt;
  int          pending;
  int          checked;
  int          clipped;
  int          items_sent;
  int          burst_left;
  bit          hold_req;
  bit          hold_done;

  snd_in_if  in_c ();
  snd_out_if out_c ();

  sigmoid_neuron_delta_rule i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_c),
    .out_o     (out_c),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  snd_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_c      (in_c),
    .out_c     (out_c),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending),
    .checked_o (checked),
    .clipped_o (clipped)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: alternate open stretches and random stalls; honor one long
  // hold-off on request so the block backs up into its input.
  initial begin
    int stretch;
    int mode;
    out_c.ready = 1'b0;
    forever begin
      stretch = $urandom_range(5, 60);
      mode    = $urandom_range(0, 3);
      repeat (stretch) begin
        @(negedge clk_i);
        if (hold_req && !hold_done) begin
          out_c.ready <= 1'b0;
          repeat (400) @(negedge clk_i);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_c.ready <= 1'b1;
          1: out_c.ready <= ($urandom_range(0, 1) == 0);
          2: out_c.ready <= ($urandom_range(0, 7) == 0);
          default: out_c.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Q4.12 value: mostly modest, sometimes full range or an extreme
  function automatic logic signed [15:0] pick_q();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
    endcase
  endfunction

  // Offer one item and hold it until taken. Enter and leave at a falling edge.
  task automatic push_item(logic [2:0] op, logic [3:0] ix, logic signed [15:0] v,
                           logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_c.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_c.valid  <= 1'b1;
    in_c.opcode <= op;
    in_c.index  <= ix;
    in_c.value  <= v;
    in_c.last   <= lst;
    do @(posedge clk_i); while (!in_c.ready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid, let every result drain, then cover the silent items' latency.
  task automatic settle();
    in_c.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Load the first count inputs (some skipped), fire the forward pass on the final one.
  task automatic forward_pass(int count);
    for (int i = 0; i < count; i++)
      if (i == count - 1 || $urandom_range(0, 5) != 0)
        push_item(OP_INPUT, 4'(i), pick_q(), i == count - 1);
  endtask

  task automatic random_sequence();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        forward_pass(N_IN);
        if ($urandom_range(0, 3) != 0)
          push_item(OP_TRAIN, 4'($urandom), $urandom_range(0, 2) ? 16'($urandom_range(0, 4096))
                                                                 : pick_q(), 1'($urandom));
        repeat ($urandom_range(0, 3))
          push_item($urandom_range(0, 1) ? OP_RDW : OP_RDE, 4'($urandom), 16'($urandom),
                    1'($urandom));
      end
      5: repeat ($urandom_range(1, 5)) push_item(OP_WRW, 4'($urandom), pick_q(), 1'($urandom));
      6: repeat ($urandom_range(1, 4))
        push_item($urandom_range(0, 1) ? OP_RDW : OP_RDE, 4'($urandom), 16'($urandom),
                  1'($urandom));
      7: push_item(OP_TRAIN, 4'($urandom), pick_q(), 1'($urandom));
      8: push_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 4'($urandom), 16'($urandom),
                   1'($urandom));
      default: forward_pass($urandom_range(1, N_IN));
    endcase
  endtask

  initial begin
    logic [15:0] rate_set[N_PHASE];
    logic [15:0] decay_set[N_PHASE];
    int          goal;
    rate_set  = '{16'd6554, 16'hffff, 16'd0, 16'($urandom), 16'd1, 16'd40000};
    decay_set = '{16'd0, 16'd0, 16'hffff, 16'($urandom), 16'd300, 16'd1};
    rst_ni      = 1'b0;
    in_c.valid  = 1'b0;
    in_c.opcode = OP_INPUT;
    in_c.index  = '0;
    in_c.value  = '0;
    in_c.last   = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_HIDDEN;
    cfg_data    = '0;
    items_sent  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset state, extremes, every opcode, ignored items.
    push_item(OP_TRAIN, 4'd0, 16'sd2048, 1'b0);      // train with no forward pass yet
    push_item(OP_RDE, 4'd3, 16'sd0, 1'b0);
    push_item(OP_RDW, 4'd15, 16'sd0, 1'b0);
    push_item(OP_WRW, 4'd0, 16'sh7fff, 1'b0);
    push_item(OP_WRW, 4'd15, 16'sh8000, 1'b1);
    push_item(OP_INPUT, 4'd0, 16'sh7fff, 1'b0);      // input without last: silent
    push_item(OP_INPUT, 4'd15, 16'sh8000, 1'b1);     // huge positive sum, clips
    push_item(OP_TRAIN, 4'd0, 16'sh7fff, 1'b0);
    push_item(OP_RDW, 4'd0, 16'sd0, 1'b0);
    push_item(OP_RDW, 4'd15, 16'sd0, 1'b0);
    push_item(OP_RDE, 4'd0, 16'sd0, 1'b0);
    push_item(OP_RDE, 4'd15, 16'sd0, 1'b0);
    push_item(OP_SPARE_LO, 4'd5, 16'sh7fff, 1'b1);
    push_item(OP_SPARE_HI, 4'd10, 16'sh8000, 1'b0);
    push_item(OP_INPUT, 4'd0, 16'sh7fff, 1'b1);      // big positive sum
    push_item(OP_TRAIN, 4'd0, 16'sh8000, 1'b0);
    push_item(OP_RDE, 4'd0, 16'sd0, 1'b0);
    push_item(OP_INPUT, 4'd0, 16'sd0, 1'b0);
    push_item(OP_INPUT, 4'd15, 16'sd0, 1'b1);        // zero sum, mid-table
    push_item(OP_TRAIN, 4'd0, 16'sd4096, 1'b0);
    settle();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < N_PHASE; ph++) begin
      write_reg(CFG_HIDDEN, 16'(ph % 2));
      write_reg(CFG_IRATE, rate_set[ph]);
      write_reg(CFG_DECAY, decay_set[ph]);
      if (ph == 2) write_reg(CFG_NONE, 16'hffff);
      goal = items_sent + ITEM_GOAL / N_PHASE;
      while (items_sent < goal) begin
        // ask for the long receiver hold-off once, midway through
        if (ph == 3 && !hold_req) hold_req = 1'b1;
        random_sequence();
      end
      settle();
    end

    repeat (60) @(negedge clk_i);
    $display("Run covered %0d items over %0d register settings; %0d results checked,",
             items_sent, N_PHASE + 1, checked);
    $display("%0d of them flagged as clipped, with a long output hold-off midway.", clipped);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: end the run if the handshakes hang.
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending);
    $display("FAILURE");
    $finish;
  end

endmodule
